>>> design/tcw_pkg.sv
// Shared types and constants of the text console writer.
// No dependencies; tcw_cursor, text_console_writer and tcw_checker refer to it by scoped names.
`default_nettype none

package tcw_pkg;

  // Default screen geometry.
  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  // Field widths of a screen cell and of the configuration port.
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned COLOR_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Command codes.
  localparam logic [2:0] ACT_WRITE_CHAR   = 3'd0;
  localparam logic [2:0] ACT_CLEAR_SCREEN = 3'd1;
  localparam logic [2:0] ACT_SET_CURSOR   = 3'd2;
  localparam logic [2:0] ACT_SCROLL       = 3'd3;
  localparam logic [2:0] ACT_CLEAR_LINE   = 3'd4;
  localparam logic [2:0] ACT_READ_CELL    = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 2'd1;

  // Character codes with special handling.
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  // One command transaction.
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_code;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] amount;
  } tcw_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic [7:0]  cell_char;
    logic [3:0]  cell_fg;
    logic [3:0]  cell_bg;
  } tcw_res_t;

  // Requests from the sequencer to the cursor unit.
  typedef struct packed {
    logic load;
    logic advance;
    logic newline;
    logic tab;
  } tcw_cur_ctrl_t;

endpackage

`default_nettype wire

>>> design/tcw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; used for the screen store.
`default_nettype none

module tcw_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 2000,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; read data is registered and appears in the cycle after an address taken with re high.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/tcw_cursor.sv
// Cursor unit: column, row and linear offset registers and their advance logic.
// Depends on tcw_pkg for the control struct.
`default_nettype none

module tcw_cursor #(
  parameter  int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter  int unsigned ROWS    = tcw_pkg::ROWS_DEF,
  localparam int unsigned COL_W   = $clog2(COLUMNS),
  localparam int unsigned LINE_W  = $clog2(ROWS),
  localparam int unsigned ADDR_W  = $clog2(COLUMNS * ROWS)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tcw_pkg::tcw_cur_ctrl_t ctrl_i,
  input  wire logic     [COL_W-1:0]  set_col_i,
  input  wire logic     [LINE_W-1:0] set_row_i,
  input  wire logic     [ADDR_W-1:0] set_off_i,
  output logic          [COL_W-1:0]  col_o,
  output logic          [LINE_W-1:0] line_o,
  output logic          [ADDR_W-1:0] off_o,
  output logic                       scroll_req_o
);

  localparam logic [ADDR_W-1:0] LAST_ROW_OFF = ADDR_W'((ROWS - 1) * COLUMNS);

  logic [COL_W-1:0]  col_q, col_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [ADDR_W-1:0] off_q, off_d;
  logic [COL_W:0]    step;
  logic [COL_W:0]    col_sum;
  logic              wrap;
  logic              bottom;

  // A tab moves two cells, anything else one.
  assign step    = ctrl_i.tab ? (COL_W + 1)'(2) : (COL_W + 1)'(1);
  assign col_sum = {1'b0, col_q} + step;
  assign wrap    = ctrl_i.newline || (32'(col_sum) >= COLUMNS);
  assign bottom  = (32'(line_q) == ROWS - 1);

  // Wrapping past the last row asks the sequencer for a one-line scroll.
  assign scroll_req_o = wrap && bottom;

  // Next cursor position.
  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    off_d  = off_q;
    if (ctrl_i.load) begin
      col_d  = set_col_i;
      line_d = set_row_i;
      off_d  = set_off_i;
    end else if (ctrl_i.advance) begin
      if (wrap) begin
        col_d = '0;
        if (bottom) begin
          off_d = LAST_ROW_OFF;
        end else begin
          line_d = line_q + LINE_W'(1);
          off_d  = off_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS);
        end
      end else begin
        col_d = col_sum[COL_W-1:0];
        off_d = off_q + ADDR_W'(step);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
      off_q  <= '0;
    end else begin
      col_q  <= col_d;
      line_q <= line_d;
      off_q  <= off_d;
    end
  end

  assign col_o  = col_q;
  assign line_o = line_q;
  assign off_o  = off_q;

endmodule

`default_nettype wire

>>> design/text_console_writer.sv
// Top level of the text console writer: command sequencer, color registers, screen store.
// Depends on tcw_pkg, tcw_ram and tcw_cursor.
//
// Usage:
//   A command is taken at a rising edge with start high and busy low. Its result
//   shows on result_o for exactly one cycle with result_valid_o high; the receiver
//   cannot stall it. busy is already low in the strobe cycle, so the next command
//   may be taken at the edge that ends it.
//   Work per command: a plain character, newline, set cursor, unused code, a
//   scroll of zero lines or a clear of a line past the last row pass only the
//   exec state; a tab or a cell read adds a second store access; clear line
//   walks COLUMNS cells and clear screen COLUMNS*ROWS; a scroll or a character
//   that scrolls the screen copies the kept lines up, then blanks the rest. The
//   single write port of the screen store, one cell per cycle, sets these walks.
//   Colors are written through the cfg channel, which is always ready; a write to
//   an index beyond the back color is dropped.
//   After reset the block zeroes all COLUMNS*ROWS cells (2000 by default) of the
//   screen store, one cell per cycle, with busy high. Cursor and colors reset
//   at once (cursor 0,0; text color 15; back color 0).
`default_nettype none

module text_console_writer #(
  parameter  int unsigned COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter  int unsigned ROWS      = tcw_pkg::ROWS_DEF,
  localparam int unsigned CFG_IDX_W = tcw_pkg::CFG_IDX_W,
  localparam int unsigned COLOR_W   = tcw_pkg::COLOR_W
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  input  wire tcw_pkg::tcw_cmd_t      cmd_i,
  output logic                        busy,
  output logic                        result_valid_o,
  output tcw_pkg::tcw_res_t           result_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [COLOR_W-1:0]     cfg_data_i
);

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned LINE_W = $clog2(ROWS);
  localparam int unsigned CELL_W = tcw_pkg::CELL_W;
  localparam logic [CNT_W-1:0]  CELLS_CNT = CNT_W'(CELLS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_TAB2 = 6'b000100,
    ST_READ = 6'b001000,
    ST_COPY = 6'b010000,
    ST_FILL = 6'b100000
  } tcw_state_e;

  function automatic logic [CELL_W-1:0] make_cell(logic [7:0] ch, logic [COLOR_W-1:0] fg,
                                                  logic [COLOR_W-1:0] bg);
    return {bg, fg, ch};
  endfunction

  tcw_state_e            state_q, state_d;
  tcw_pkg::tcw_cmd_t     cmd_q;
  logic [COLOR_W-1:0]    text_q, back_q;
  logic                  init_q, init_d;
  logic                  done_q, done_d;
  logic [CELL_W-1:0]     cell_q, cell_d;
  logic [CNT_W-1:0]      src_q, src_d;
  logic [CNT_W-1:0]      dst_q, dst_d;
  logic [CNT_W-1:0]      end_q, end_d;
  logic                  pend_q, pend_d;
  logic                  accept;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [CELL_W-1:0]     wdata;
  logic                  re;
  logic [ADDR_W-1:0]     raddr;
  logic [CELL_W-1:0]     rdata;
  logic [CELL_W-1:0]     blank;

  logic [COL_W-1:0]      col_cl;
  logic [LINE_W-1:0]     row_cl;
  logic [7:0]            amount_sat;
  logic [7:0]            mul_in;
  logic [15:0]           mul_prod;
  logic [ADDR_W-1:0]     cell_addr;
  logic [CNT_W-1:0]      line_base;

  tcw_pkg::tcw_cur_ctrl_t cur_ctrl;
  logic [COL_W-1:0]      cur_col;
  logic [LINE_W-1:0]     cur_line;
  logic [ADDR_W-1:0]     cur_off;
  logic                  scroll_req;

  logic [31:0]           col_ext, line_ext, off_ext;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign blank       = make_cell(8'h00, text_q, back_q);

  // Color registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q <= COLOR_W'(15);
      back_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tcw_pkg::CFG_TEXT_COLOR: text_q <= cfg_data_i;
        tcw_pkg::CFG_BACK_COLOR: back_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Command register, loaded on each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  // Clamped coordinates and one shared multiply by the row length.
  always_comb begin
    col_cl = (cmd_q.column >= 8'(COLUMNS)) ? COL_W'(COLUMNS - 1) : cmd_q.column[COL_W-1:0];
    row_cl = (cmd_q.row >= 8'(ROWS)) ? LINE_W'(ROWS - 1) : cmd_q.row[LINE_W-1:0];
    amount_sat = (cmd_q.amount > 8'(ROWS)) ? 8'(ROWS) : cmd_q.amount;
    case (cmd_q.action)
      tcw_pkg::ACT_SCROLL:     mul_in = amount_sat;
      tcw_pkg::ACT_CLEAR_LINE: mul_in = cmd_q.amount;
      default:                 mul_in = 8'(row_cl);
    endcase
  end

  assign mul_prod  = 16'(mul_in) * 16'(COLUMNS);
  assign cell_addr = ADDR_W'(mul_prod + 16'(col_cl));
  assign line_base = CNT_W'(mul_prod);

  // Sequencer. Reads and writes of the store never touch the same cell in one
  // cycle: a copy reads ahead of the cells it writes, and a cell read starts only
  // after every earlier write has landed.
  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    done_d  = 1'b0;
    cell_d  = cell_q;
    src_d   = src_q;
    dst_d   = dst_q;
    end_d   = end_q;
    pend_d  = pend_q;
    we      = 1'b0;
    waddr   = dst_q[ADDR_W-1:0];
    wdata   = blank;
    re      = 1'b0;
    raddr   = cell_addr;
    cur_ctrl         = '0;
    cur_ctrl.newline = (cmd_q.char_code == tcw_pkg::CHAR_NEWLINE);
    cur_ctrl.tab     = (cmd_q.char_code == tcw_pkg::CHAR_TAB);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cell_d  = '0;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (cmd_q.action)
          tcw_pkg::ACT_WRITE_CHAR: begin
            if (cur_ctrl.tab) begin
              we      = 1'b1;
              waddr   = cur_off;
              wdata   = make_cell(tcw_pkg::CHAR_SPACE, text_q, back_q);
              state_d = ST_TAB2;
            end else begin
              if (!cur_ctrl.newline) begin
                we    = 1'b1;
                waddr = cur_off;
                wdata = make_cell(cmd_q.char_code, text_q, back_q);
              end
              cur_ctrl.advance = 1'b1;
              if (scroll_req) begin
                src_d   = CNT_W'(COLUMNS);
                dst_d   = '0;
                pend_d  = 1'b0;
                state_d = ST_COPY;
              end else begin
                done_d  = 1'b1;
                state_d = ST_IDLE;
              end
            end
          end
          tcw_pkg::ACT_CLEAR_SCREEN: begin
            dst_d   = '0;
            end_d   = CELLS_CNT;
            state_d = ST_FILL;
          end
          tcw_pkg::ACT_SET_CURSOR: begin
            cur_ctrl.load = 1'b1;
            done_d        = 1'b1;
            state_d       = ST_IDLE;
          end
          tcw_pkg::ACT_SCROLL: begin
            if (amount_sat == 8'd0) begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end else begin
              src_d   = line_base;
              dst_d   = '0;
              pend_d  = 1'b0;
              state_d = ST_COPY;
            end
          end
          tcw_pkg::ACT_CLEAR_LINE: begin
            if (cmd_q.amount < 8'(ROWS)) begin
              dst_d   = line_base;
              end_d   = line_base + CNT_W'(COLUMNS);
              state_d = ST_FILL;
            end else begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end
          end
          tcw_pkg::ACT_READ_CELL: begin
            re      = 1'b1;
            raddr   = cell_addr;
            state_d = ST_READ;
          end
          default: begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        endcase
      end

      // Second space of a tab, dropped past the last cell.
      ST_TAB2: begin
        if (cur_off != LAST_CELL) begin
          we    = 1'b1;
          waddr = cur_off + ADDR_W'(1);
          wdata = make_cell(tcw_pkg::CHAR_SPACE, text_q, back_q);
        end
        cur_ctrl.advance = 1'b1;
        if (scroll_req) begin
          src_d   = CNT_W'(COLUMNS);
          dst_d   = '0;
          pend_d  = 1'b0;
          state_d = ST_COPY;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_READ: begin
        cell_d  = rdata;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      // Move kept lines up: read one cell ahead, write it back in the following cycle.
      ST_COPY: begin
        if (src_q != CELLS_CNT) begin
          re    = 1'b1;
          raddr = src_q[ADDR_W-1:0];
          src_d = src_q + CNT_W'(1);
        end
        pend_d = (src_q != CELLS_CNT);
        if (pend_q) begin
          we    = 1'b1;
          waddr = dst_q[ADDR_W-1:0];
          wdata = rdata;
          dst_d = dst_q + CNT_W'(1);
        end
        if ((src_q == CELLS_CNT) && !pend_q) begin
          end_d   = CELLS_CNT;
          state_d = ST_FILL;
        end
      end

      // Blank a run of cells; the pass after reset writes zeros instead.
      ST_FILL: begin
        we    = 1'b1;
        waddr = dst_q[ADDR_W-1:0];
        wdata = init_q ? '0 : blank;
        dst_d = dst_q + CNT_W'(1);
        if (dst_q == end_q - CNT_W'(1)) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
          done_d  = !init_q;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      init_q  <= 1'b1;
      done_q  <= 1'b0;
      src_q   <= '0;
      dst_q   <= '0;
      end_q   <= CELLS_CNT;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      done_q  <= done_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      end_q   <= end_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  // Screen store.
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Cursor registers.
  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (cur_ctrl),
    .set_col_i    (col_cl),
    .set_row_i    (row_cl),
    .set_off_i    (cell_addr),
    .col_o        (cur_col),
    .line_o       (cur_line),
    .off_o        (cur_off),
    .scroll_req_o (scroll_req)
  );

  // Result: the cursor is final by the strobe cycle, masked to the field widths.
  assign col_ext  = 32'(cur_col);
  assign line_ext = 32'(cur_line);
  assign off_ext  = 32'(cur_off);

  always_comb begin
    result_o.cursor_column = col_ext[6:0];
    result_o.cursor_row    = line_ext[4:0];
    result_o.cursor_offset = off_ext[10:0];
    result_o.cell_char     = cell_q[7:0];
    result_o.cell_fg       = cell_q[11:8];
    result_o.cell_bg       = cell_q[15:12];
  end

  assign result_valid_o = done_q;

endmodule

`default_nettype wire

>>> design/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level.
// Depends on tcw_pkg and on the port list of text_console_writer.
`default_nettype none

module tcw_checker #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              result_valid_o,
  input wire tcw_pkg::tcw_res_t result_o
);

  // A result is strobed only once the block is free for the next transaction.
  a_result_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobed while busy");

  // An accepted transaction keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("not busy after accepting a command");

  // Every result ends a stretch of work.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without preceding work");

  // The reported cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((32'(result_o.cursor_column) < COLUMNS) &&
                        (32'(result_o.cursor_row) < ROWS)))
    else $error("cursor off screen");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

`default_nettype wire
